[src/rbsc_pkg.sv]
package rbsc_pkg;

    // bank geometry
    localparam int IMAGE_BYTES = 20;
    localparam int BLOCK_BYTES = 4;
    localparam int NUM_RELAYS = 160;

    localparam int BLOCK_COUNT = (IMAGE_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int FULL_BLOCKS = IMAGE_BYTES / BLOCK_BYTES;
    localparam int IMAGE_BITS = IMAGE_BYTES * 8;
    localparam int BLOCK_BITS = BLOCK_BYTES * 8;
    localparam int COUNTED_RELAYS = (NUM_RELAYS < IMAGE_BITS) ? NUM_RELAYS : IMAGE_BITS;

    // derived widths
    localparam int REL_BLOCKS = 256 / BLOCK_BITS;
    localparam int BID_W = (REL_BLOCKS > 8) ? $clog2(REL_BLOCKS) : 3;
    localparam int BP_W = $clog2(BLOCK_BITS);
    localparam int IDX_W = $clog2(BLOCK_BITS + 1);
    localparam int CA_W = $clog2(NUM_RELAYS);
    localparam int REL_W = 10;

    // command codes
    localparam logic [3:0] CMD_ONE_ON        = 4'd0;
    localparam logic [3:0] CMD_ONE_OFF       = 4'd1;
    localparam logic [3:0] CMD_ON_MASK       = 4'd2;
    localparam logic [3:0] CMD_OFF_MASK      = 4'd3;
    localparam logic [3:0] CMD_TOGGLE_MASK   = 4'd4;
    localparam logic [3:0] CMD_COUNTER_READ  = 4'd5;
    localparam logic [3:0] CMD_COUNTER_WRITE = 4'd6;
    localparam logic [3:0] CMD_CLEAR_IMAGES  = 4'd7;
    localparam logic [3:0] CMD_SCAN_CHANGES  = 4'd8;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  relay_num;
        logic [2:0]  block_index;
        logic [31:0] bit_mask;
        logic [31:0] write_value;
    } relay_in_t;

    typedef struct packed {
        logic        status;
        logic [31:0] counter_value;
        logic [31:0] block_state;
        logic [7:0]  changed_blocks;
    } relay_out_t;

endpackage

[src/rbsc_ram.sv]
module rbsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/relay_bank_with_switch_counters.sv]
// sequence: counter reads pass through ST_CREAD, other non-image commands go straight to ST_DONE,
// and image commands first walk over the block's counters in ST_COUNT before ST_DONE
// flow: one command at a time, the next transfer taken in the cycle after the result is loaded;
// the counter ram port serves one counter per cycle
// reset: images, change flags and counter valid bits clear at once; counters read as zero
// until written, so no clearing pass is needed
module relay_bank_with_switch_counters
    import rbsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  relay_in_t  in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output relay_out_t out_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_COUNT, ST_CREAD, ST_DONE} state_t;

    state_t                  state_reg, state_next;
    logic [IMAGE_BITS-1:0]   image_reg, image_next;
    logic [IMAGE_BITS-1:0]   announced_reg, announced_next;
    logic [BLOCK_COUNT-1:0]  flags_reg, flags_next;
    logic [NUM_RELAYS-1:0]   cnt_valid_reg, cnt_valid_next;
    logic [BID_W-1:0]        blk_reg, blk_next;
    logic [BLOCK_BITS-1:0]   rise_reg, rise_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    pend_reg, pend_next;
    logic [CA_W-1:0]         pend_addr_reg, pend_addr_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    status_reg, status_next;
    logic [31:0]             cval_reg, cval_next;
    logic                    out_valid_reg, out_valid_next;
    relay_out_t              out_reg, out_next;

    logic                    accept;
    logic [BID_W-1:0]        sel_blk;
    logic [BP_W-1:0]         bit_pos;
    logic [BLOCK_BITS-1:0]   bit_one;
    logic [BLOCK_BITS-1:0]   mask;
    logic [BLOCK_BITS-1:0]   old_blk;
    logic [BLOCK_BITS-1:0]   new_blk;
    logic                    relay_err;
    logic                    counter_err;
    logic                    mask_err;
    logic                    img_err;
    logic [REL_W-1:0]        cur_rel;
    logic                    issue;
    logic                    ram_we;
    logic [CA_W-1:0]         ram_waddr;
    logic [31:0]             ram_wdata;
    logic                    ram_re;
    logic [CA_W-1:0]         ram_raddr;
    logic [31:0]             ram_rdata;
    logic [31:0]             ram_value;
    logic [7:0]              flag_map;

    // image of one block, bytes beyond the image read as zero
    function automatic logic [BLOCK_BITS-1:0] read_block(
        input logic [IMAGE_BITS-1:0] img,
        input logic [BID_W-1:0]      blk
    );
        logic [BLOCK_BITS-1:0] v;
        v = '0;
        for (int p = 0; p < IMAGE_BYTES; p++)
        begin
            if (BID_W'(p / BLOCK_BYTES) == blk)
            begin
                v[(p % BLOCK_BYTES)*8 +: 8] = img[p*8 +: 8];
            end
        end
        return v;
    endfunction

    rbsc_ram #(
        .WIDTH (32),
        .DEPTH (NUM_RELAYS)
    ) u_counters (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // counter value as stored, zero if never written
    assign ram_value = rd_valid_reg ? ram_rdata : 32'd0;

    // command decode and range checks
    always_comb
    begin
        relay_err   = (9'(in_data.relay_num) >= 9'(COUNTED_RELAYS));
        counter_err = (9'(in_data.relay_num) >= 9'(NUM_RELAYS));
        mask_err    = (6'(in_data.block_index) >= 6'(FULL_BLOCKS));
        img_err     = 1'b0;
        sel_blk     = BID_W'(in_data.block_index);
        case (in_data.cmd) inside
            CMD_ONE_ON, CMD_ONE_OFF:
            begin
                img_err = relay_err;
                sel_blk = BID_W'(in_data.relay_num / BLOCK_BITS);
            end
            CMD_ON_MASK, CMD_OFF_MASK, CMD_TOGGLE_MASK:
            begin
                img_err = mask_err;
            end
            CMD_COUNTER_READ, CMD_COUNTER_WRITE:
            begin
                sel_blk = BID_W'(in_data.relay_num / BLOCK_BITS);
            end
            default:
            begin
                sel_blk = BID_W'(in_data.block_index);
            end
        endcase
    end

    // new image of the addressed block
    always_comb
    begin
        bit_pos = BP_W'(in_data.relay_num % BLOCK_BITS);
        bit_one = BLOCK_BITS'(1) << bit_pos;
        mask    = in_data.bit_mask[BLOCK_BITS-1:0];
        old_blk = read_block(image_reg, sel_blk);
        new_blk = old_blk;
        case (in_data.cmd)
            CMD_ONE_ON:      new_blk = old_blk | bit_one;
            CMD_ONE_OFF:     new_blk = old_blk & ~bit_one;
            CMD_ON_MASK:     new_blk = old_blk | mask;
            CMD_OFF_MASK:    new_blk = old_blk & ~mask;
            CMD_TOGGLE_MASK:
            begin
                for (int i = 0; i < BLOCK_BYTES; i++)
                begin
                    if (mask[i*8 +: 8] != 8'd0)
                    begin
                        if ((old_blk[i*8 +: 8] & mask[i*8 +: 8]) != 8'd0)
                        begin
                            new_blk[i*8 +: 8] = old_blk[i*8 +: 8] & ~mask[i*8 +: 8];
                        end
                        else
                        begin
                            new_blk[i*8 +: 8] = old_blk[i*8 +: 8] | mask[i*8 +: 8];
                        end
                    end
                end
            end
            default:         new_blk = old_blk;
        endcase
    end

    // counter walk step
    always_comb
    begin
        cur_rel = REL_W'(blk_reg) * REL_W'(BLOCK_BITS) + REL_W'(idx_reg);
        issue   = (state_reg == ST_COUNT) && (idx_reg < IDX_W'(BLOCK_BITS))
                  && rise_reg[idx_reg[BP_W-1:0]] && (cur_rel < REL_W'(COUNTED_RELAYS));
    end

    // counter ram ports
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = CA_W'(cur_rel);
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_value + 32'd1;
        if (issue)
        begin
            ram_re = 1'b1;
        end
        else if (accept && in_data.cmd == CMD_COUNTER_READ && !counter_err)
        begin
            ram_re    = 1'b1;
            ram_raddr = in_data.relay_num[CA_W-1:0];
        end
        if (pend_reg)
        begin
            ram_we = 1'b1;
        end
        else if (accept && in_data.cmd == CMD_COUNTER_WRITE && !counter_err)
        begin
            ram_we    = 1'b1;
            ram_waddr = in_data.relay_num[CA_W-1:0];
            ram_wdata = in_data.write_value;
        end
    end

    // flag bitmap for the result
    always_comb
    begin
        flag_map = 8'd0;
        for (int b = 0; b < BLOCK_COUNT && b < 8; b++)
        begin
            flag_map[b] = flags_reg[b];
        end
    end

    // next state of the sequencer and the stored image
    always_comb
    begin
        state_next     = state_reg;
        image_next     = image_reg;
        announced_next = announced_reg;
        flags_next     = flags_reg;
        cnt_valid_next = cnt_valid_reg;
        blk_next       = blk_reg;
        rise_next      = rise_reg;
        idx_next       = idx_reg;
        pend_next      = issue;
        pend_addr_next = ram_raddr;
        rd_valid_next  = ram_re ? cnt_valid_reg[ram_raddr] : 1'b0;
        status_next    = status_reg;
        cval_next      = cval_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (ram_we)
        begin
            cnt_valid_next[ram_waddr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    blk_next    = sel_blk;
                    rise_next   = new_blk & ~old_blk;
                    idx_next    = '0;
                    cval_next   = 32'd0;
                    status_next = 1'b0;
                    state_next  = ST_DONE;
                    case (in_data.cmd) inside
                        CMD_ONE_ON, CMD_ONE_OFF, CMD_ON_MASK, CMD_OFF_MASK,
                        CMD_TOGGLE_MASK:
                        begin
                            status_next = img_err;
                            if (!img_err)
                            begin
                                for (int p = 0; p < IMAGE_BYTES; p++)
                                begin
                                    if (BID_W'(p / BLOCK_BYTES) == sel_blk)
                                    begin
                                        image_next[p*8 +: 8] =
                                            new_blk[(p % BLOCK_BYTES)*8 +: 8];
                                    end
                                end
                                state_next = ST_COUNT;
                            end
                        end
                        CMD_COUNTER_READ:
                        begin
                            status_next = counter_err;
                            if (!counter_err)
                            begin
                                state_next = ST_CREAD;
                            end
                        end
                        CMD_COUNTER_WRITE:
                        begin
                            status_next = counter_err;
                        end
                        CMD_CLEAR_IMAGES:
                        begin
                            image_next     = '0;
                            announced_next = '0;
                            flags_next     = '0;
                        end
                        CMD_SCAN_CHANGES:
                        begin
                            for (int p = 0; p < IMAGE_BYTES; p++)
                            begin
                                if (image_reg[p*8 +: 8] != announced_reg[p*8 +: 8])
                                begin
                                    flags_next[p / BLOCK_BYTES] = 1'b1;
                                end
                            end
                            announced_next = image_reg;
                        end
                        default:
                        begin
                            status_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_COUNT:
            begin
                // one counter per cycle, write-back follows in the cycle after the read
                if (idx_reg == IDX_W'(BLOCK_BITS))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_CREAD:
            begin
                cval_next  = ram_value;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status         = status_reg;
                    out_next.counter_value  = cval_reg;
                    out_next.block_state    = status_reg ? 32'd0
                                              : 32'(read_block(image_reg, blk_reg));
                    out_next.changed_blocks = flag_map;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            image_reg     <= '0;
            announced_reg <= '0;
            flags_reg     <= '0;
            cnt_valid_reg <= '0;
            blk_reg       <= '0;
            rise_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            status_reg    <= 1'b0;
            cval_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            image_reg     <= image_next;
            announced_reg <= announced_next;
            flags_reg     <= flags_next;
            cnt_valid_reg <= cnt_valid_next;
            blk_reg       <= blk_next;
            rise_reg      <= rise_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            rd_valid_reg  <= rd_valid_next;
            status_reg    <= status_next;
            cval_reg      <= cval_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // a result is only loaded from the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside done state");

    // an error result reports an empty block and no counter
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status |-> out_reg.block_state == 32'd0
                                            && out_reg.counter_value == 32'd0)
        else $error("error result carries data");

    // write-back never hits the counter being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |-> ram_waddr != ram_raddr)
        else $error("counter read and write collide");

    // no write-back is pending once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_reg)
        else $error("pending counter update in idle");

endmodule
